/* design/assert_macros.svh */
// Assertion macros used by the file that checks the renderer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on an explicit clock, disabled while the given reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property on the block clock, disabled during reset.
`define ASSERT_TOP(lbl, prop, msg) `ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

/* design/ssr_pkg.sv */
// Shared types, codes and tables of the seven-segment text renderer.
`default_nettype none

package ssr_pkg;

   // Command codes of the input channel.
   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_FETCH  = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Character codes of the picture.
   localparam logic [6:0] CH_SPACE = 7'd32;
   localparam logic [6:0] CH_DASH  = 7'd45;
   localparam logic [6:0] CH_BAR   = 7'd124;

   // Register file layout and reset values.
   localparam int         CSR_ADDR_W     = 3;
   localparam logic       CSR_IDX_SCALE  = 1'b0;
   localparam logic [3:0] SCALE_RESET    = 4'd1;

   // Defaults of the top-level parameters.
   localparam int MAX_DIGITS_DEFAULT  = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Segment bit positions.
   localparam int SEG_TOP   = 0;
   localparam int SEG_UL    = 1;
   localparam int SEG_UR    = 2;
   localparam int SEG_MID   = 3;
   localparam int SEG_LL    = 4;
   localparam int SEG_LR    = 5;
   localparam int SEG_BOT   = 6;

   // One command as it travels from the front end to the back end.
   typedef struct packed {
      logic [1:0] cmd;
      logic [3:0] digit;
   } ssr_item_type;

   // One rendered character.
   typedef struct packed {
      logic [6:0] char_code;
      logic       row_end;
      logic       frame_end;
   } ssr_result_type;

   // Configuration seen by the back end.
   typedef struct packed {
      logic [3:0] scale;
      logic       restart;
   } ssr_cfg_type;

   // Maps a digit code to its lit segments; codes above nine are blank.
   function automatic logic [6:0] seg_lookup(input logic [3:0] code);
      logic [6:0] segs;
      unique case (code)
         4'd0:    segs = 7'h77;
         4'd1:    segs = 7'h24;
         4'd2:    segs = 7'h5D;
         4'd3:    segs = 7'h6D;
         4'd4:    segs = 7'h2E;
         4'd5:    segs = 7'h6B;
         4'd6:    segs = 7'h7B;
         4'd7:    segs = 7'h25;
         4'd8:    segs = 7'h7F;
         4'd9:    segs = 7'h6F;
         default: segs = 7'h00;
      endcase
      return segs;
   endfunction

endpackage

`default_nettype wire

/* design/ssr_fifo.sv */
// Small first-in first-out queue used between the renderer stages.
`default_nettype none

module ssr_fifo #(
   parameter int WIDTH = 6,
   parameter int DEPTH = ssr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = data_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* design/ssr_front.sv */
// Front end of the renderer: accepts commands and drops unused codes.
`default_nettype none

module ssr_front (
   input  wire logic                 req_push,
   input  wire logic [1:0]           req_cmd,
   input  wire logic [3:0]           req_digit,
   output logic                      req_full,
   output logic                      q_push,
   output ssr_pkg::ssr_item_type     q_item,
   input  wire logic                 q_full
);

   logic accept;
   logic known;

   // A transfer happens whenever the command queue has room.
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // Only append, fetch and clear reach the back end.
   always_comb begin
      unique case (req_cmd)
         ssr_pkg::CMD_APPEND: known = 1'b1;
         ssr_pkg::CMD_FETCH:  known = 1'b1;
         ssr_pkg::CMD_CLEAR:  known = 1'b1;
         ssr_pkg::CMD_UNUSED: known = 1'b0;
         default:             known = 1'b0;
      endcase
   end

   assign q_push       = accept && known;
   assign q_item.cmd   = req_cmd;
   assign q_item.digit = req_digit;

endmodule

`default_nettype wire

/* design/ssr_back.sv */
// Back end of the renderer: digit buffer, picture position and character generation.
`default_nettype none

module ssr_back #(
   parameter int MAX_DIGITS = ssr_pkg::MAX_DIGITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  ssr_pkg::ssr_cfg_type       cfg,
   input  wire logic                  cmd_valid,
   input  ssr_pkg::ssr_item_type      cmd_item,
   output logic                       cmd_pop,
   output logic                       res_push,
   output ssr_pkg::ssr_result_type    res_data,
   input  wire logic                  res_full
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   logic [3:0]       store_ff [MAX_DIGITS];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [5:0]       row_ff, row_in;
   logic [IDX_W-1:0] cell_ff, cell_in;
   logic [4:0]       col_ff, col_in;

   logic             go, is_fetch, is_append, is_clear, store_we;
   logic [IDX_W-1:0] last_cell, cell_sel;
   logic [6:0]       segs;
   logic [4:0]       s_col, s_p1, s_p2;
   logic [5:0]       mid_row, down_row;
   logic             inner, row_end, frame_end;
   logic [6:0]       ch;

   // One command is carried out per cycle while the result queue has room.
   assign go        = cmd_valid && !res_full;
   assign cmd_pop   = go;
   assign is_append = go && (cmd_item.cmd == ssr_pkg::CMD_APPEND);
   assign is_fetch  = go && (cmd_item.cmd == ssr_pkg::CMD_FETCH);
   assign is_clear  = go && (cmd_item.cmd == ssr_pkg::CMD_CLEAR);
   assign store_we  = is_append && (count_ff < CNT_W'(MAX_DIGITS));

   // Picture geometry for the current scale.
   assign s_col    = 5'(cfg.scale);
   assign s_p1     = s_col + 5'd1;
   assign s_p2     = s_col + 5'd2;
   assign mid_row  = 6'(cfg.scale) + 6'd1;
   assign down_row = (6'(cfg.scale) << 1) + 6'd2;

   // Cell being drawn, clamped to the last buffered digit.
   assign last_cell = IDX_W'(count_ff - 1'b1);
   assign cell_sel  = (CNT_W'(cell_ff) < count_ff) ? cell_ff : last_cell;
   assign segs      = ssr_pkg::seg_lookup(store_ff[cell_sel]);
   assign inner     = (col_ff >= 5'd1) && (col_ff <= s_col);

   // Character at the current row and column.
   always_comb begin
      priority if (col_ff > s_p1) begin
         ch = ssr_pkg::CH_SPACE;
      end else if (row_ff == 6'd0) begin
         ch = (inner && segs[ssr_pkg::SEG_TOP]) ? ssr_pkg::CH_DASH : ssr_pkg::CH_SPACE;
      end else if (row_ff == mid_row) begin
         ch = (inner && segs[ssr_pkg::SEG_MID]) ? ssr_pkg::CH_DASH : ssr_pkg::CH_SPACE;
      end else if (row_ff == down_row) begin
         ch = (inner && segs[ssr_pkg::SEG_BOT]) ? ssr_pkg::CH_DASH : ssr_pkg::CH_SPACE;
      end else if (row_ff < mid_row) begin
         if ((col_ff == 5'd0) && segs[ssr_pkg::SEG_UL]) begin
            ch = ssr_pkg::CH_BAR;
         end else if ((col_ff == s_p1) && segs[ssr_pkg::SEG_UR]) begin
            ch = ssr_pkg::CH_BAR;
         end else begin
            ch = ssr_pkg::CH_SPACE;
         end
      end else begin
         if ((col_ff == 5'd0) && segs[ssr_pkg::SEG_LL]) begin
            ch = ssr_pkg::CH_BAR;
         end else if ((col_ff == s_p1) && segs[ssr_pkg::SEG_LR]) begin
            ch = ssr_pkg::CH_BAR;
         end else begin
            ch = ssr_pkg::CH_SPACE;
         end
      end
   end

   assign row_end   = (cell_sel == last_cell) && (col_ff >= s_p1);
   assign frame_end = row_end && (row_ff >= down_row);

   // Result of a fetch; an empty buffer yields a lone space that ends the frame.
   always_comb begin
      res_push = is_fetch;
      if (count_ff == '0) begin
         res_data.char_code = ssr_pkg::CH_SPACE;
         res_data.row_end   = 1'b1;
         res_data.frame_end = 1'b1;
      end else begin
         res_data.char_code = ch;
         res_data.row_end   = row_end;
         res_data.frame_end = frame_end;
      end
   end

   // Buffer fill count and picture position.
   always_comb begin
      count_in = count_ff;
      row_in   = row_ff;
      cell_in  = cell_ff;
      col_in   = col_ff;
      if (store_we) begin
         count_in = count_ff + 1'b1;
      end else if (is_clear) begin
         count_in = '0;
      end
      priority if (cfg.restart || is_append || is_clear) begin
         row_in  = '0;
         cell_in = '0;
         col_in  = '0;
      end else if (is_fetch && (count_ff != '0)) begin
         priority if (frame_end) begin
            row_in  = '0;
            cell_in = '0;
            col_in  = '0;
         end else if (row_end) begin
            row_in  = row_ff + 6'd1;
            cell_in = '0;
            col_in  = '0;
         end else if (col_ff >= s_p2) begin
            cell_in = cell_sel + 1'b1;
            col_in  = '0;
         end else begin
            col_in  = col_ff + 5'd1;
         end
      end else begin
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         row_ff   <= '0;
         cell_ff  <= '0;
         col_ff   <= '0;
      end else begin
         count_ff <= count_in;
         row_ff   <= row_in;
         cell_ff  <= cell_in;
         col_ff   <= col_in;
      end
   end

   // Digit buffer; entries above the fill count are never read.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[count_ff[IDX_W-1:0]] <= cmd_item.digit;
      end
   end

endmodule

`default_nettype wire

/* design/scaled_seven_segment_text_renderer_unit.sv */
// Top level of the seven-segment text renderer with its register port.
`default_nettype none
`include "assert_macros.svh"

// Renders buffered decimal digits as a scaled seven-segment picture, one ASCII
// character per fetch command. Commands enter through a queue-style port
// (push/full), a front end decodes them and drops the unused code, and a
// command queue of QUEUE_DEPTH entries feeds the back end, which carries out
// one command per cycle while the result queue has room, and writes each
// fetched character into a result queue of the same depth (empty/pop). The
// block sustains one command per cycle while results are taken; a fetched
// character passes through the command queue, the back end and the result
// queue before it appears on the result ports. The scale register is at byte
// address 0; writing it restarts the picture at its top row. The user must
// write it only while no command is in flight; the block does not enforce it.
module scaled_seven_segment_text_renderer_unit #(
   parameter int MAX_DIGITS  = ssr_pkg::MAX_DIGITS_DEFAULT,
   parameter int QUEUE_DEPTH = ssr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   input  wire logic [1:0]                      req_cmd,
   input  wire logic [3:0]                      req_digit,
   output logic                                 req_full,
   output logic [6:0]                           rsp_char_code,
   output logic                                 rsp_row_end,
   output logic                                 rsp_frame_end,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ssr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   localparam int ITEM_W = $bits(ssr_pkg::ssr_item_type);
   localparam int RES_W  = $bits(ssr_pkg::ssr_result_type);

   logic                    scale_wr;
   logic [3:0]              scale_ff, scale_in;
   ssr_pkg::ssr_cfg_type    cfg;
   logic                    q_push, q_full, q_empty, q_pop;
   ssr_pkg::ssr_item_type   q_item_wr, q_item_rd;
   logic                    res_push, res_full;
   ssr_pkg::ssr_result_type res_wr, res_rd;
   logic                    rsp_char_ok;

   // Register port: the scale register, always ready.
   assign csr_pready = 1'b1;
   assign scale_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == ssr_pkg::CSR_IDX_SCALE);
   assign scale_in   = scale_wr ? csr_pwdata[3:0] : scale_ff;
   assign csr_prdata = (csr_paddr[2] == ssr_pkg::CSR_IDX_SCALE) ? {28'd0, scale_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= ssr_pkg::SCALE_RESET;
      end else begin
         scale_ff <= scale_in;
      end
   end

   assign cfg.scale   = scale_ff;
   assign cfg.restart = scale_wr;

   // Command decode.
   ssr_front u_front (
      .req_push  (req_push),
      .req_cmd   (req_cmd),
      .req_digit (req_digit),
      .req_full  (req_full),
      .q_push    (q_push),
      .q_item    (q_item_wr),
      .q_full    (q_full)
   );

   // Command queue between the front and back ends.
   ssr_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_item_wr),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_item_rd),
      .empty     (q_empty)
   );

   // Command execution and character generation.
   ssr_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (!q_empty),
      .cmd_item  (q_item_rd),
      .cmd_pop   (q_pop),
      .res_push  (res_push),
      .res_data  (res_wr),
      .res_full  (res_full)
   );

   // Result queue toward the consumer.
   ssr_fifo #(
      .WIDTH (RES_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_wr),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_rd),
      .empty     (rsp_empty)
   );

   assign rsp_char_code = res_rd.char_code;
   assign rsp_row_end   = res_rd.row_end;
   assign rsp_frame_end = res_rd.frame_end;

   // The character on the result ports is one of the three picture characters.
   assign rsp_char_ok = (rsp_char_code == ssr_pkg::CH_SPACE)
                        || (rsp_char_code == ssr_pkg::CH_DASH)
                        || (rsp_char_code == ssr_pkg::CH_BAR);

   // A frame always ends on the end of a row.
   `ASSERT_TOP(a_frame_ends_row, (!rsp_empty && rsp_frame_end) |-> rsp_row_end, "frame end alone")

   // Only the three picture characters are ever produced.
   `ASSERT_TOP(a_char_legal, !rsp_empty |-> rsp_char_ok, "illegal character code")

   // A scale write is visible in the register on the next cycle.
   `ASSERT_TOP(a_scale_written, scale_wr |=> scale_ff == $past(csr_pwdata[3:0]), "scale lost")

endmodule

`default_nettype wire
